[sv/mbr_pkg.sv]
`default_nettype none
package mbr_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 16;
   localparam int BYTE_W = 8;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 6;
   localparam int TAKE_W = 4;
   localparam int OFFSET_W = 3;
   localparam logic [COUNT_W-1:0] MAX_BIT_COUNT = 6'd32;
   localparam logic [COUNT_W-1:0] GROUP_BITS = 6'd4;
   localparam int GROUP_LAST_BIT = 3;
   localparam int OVERFLOW_LSB = 29;
   localparam logic [BYTE_W-1:0] PHANTOM_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      OP_PUSH      = 2'd0,
      OP_READ_BITS = 2'd1,
      OP_READ_INT  = 2'd2,
      OP_ALIGN     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_PADDED   = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_DROPPED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD,
      S_FINISH
   } state_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [BYTE_W-1:0]  byte_value;
      logic [COUNT_W-1:0] bit_count;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] field_value;
      status_type         status;
      logic               at_end;
   } rsp_type;

   typedef struct packed {
      logic [TAKE_W-1:0]   take;
      logic [BYTE_W-1:0]   chunk;
      logic [OFFSET_W-1:0] new_offset;
      logic                byte_end;
   } funnel_type;

endpackage
`default_nettype wire

[sv/msb_bit_reader_octal_varint_top.sv]
`default_nettype none
// A push, a zero-length read or an align on a byte boundary passes from acceptance through
// S_EXEC and S_FINISH to the result register; other reads take one byte piece from the
// funnel per S_EXEC step, and each head byte fetched from RAM adds an S_LOAD step.
// One item at a time: the next item is taken in the cycle its predecessor's
// result moves into the output register. Reset clears pointers, fill count, bit offset
// and phantom state at once; byte store contents stay undefined until written.
module msb_bit_reader_octal_varint_top #(
   parameter int FIFO_DEPTH = mbr_pkg::FIFO_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mbr_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mbr_pkg::rsp_type      rsp_item
);
   import mbr_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

   state_type state_ff, state_in;

   opcode_type          op_ff, op_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [VALUE_W-1:0]  bits_ff, bits_in;
   logic [VALUE_W-1:0]  int_ff, int_in;
   logic                padded_ff, padded_in;
   logic                ovf_ff, ovf_in;
   logic                drop_ff, drop_in;

   logic [PTR_W-1:0]    rp_ff, rp_in;
   logic [PTR_W-1:0]    wp_ff, wp_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                phantom_ff, phantom_in;
   logic [BYTE_W-1:0]   head_ff, head_in;
   logic                head_valid_ff, head_valid_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                accept;
   logic                out_free;
   logic                deliver;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [BYTE_W-1:0]   ram_rd_data;

   logic                fifo_full;
   logic                fifo_empty;
   logic                use_phantom;
   logic [BYTE_W-1:0]   src_byte;
   logic                fetch_needed;
   logic                step_ok;
   logic                exec_done;
   funnel_type          fun;
   logic [VALUE_W-1:0]  step_bits;
   logic [COUNT_W-1:0]  step_rem;
   logic [TAKE_W-1:0]   group;
   logic                group_more;
   logic [PTR_W-1:0]    rp_next;
   logic [PTR_W-1:0]    wp_next;
   logic [COUNT_W-1:0]  init_rem;
   status_type          res_status;
   logic [VALUE_W-1:0]  res_value;

   mbr_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(FIFO_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(wp_ff),
      .wr_data(byte_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(rp_ff),
      .rd_data(ram_rd_data)
   );

   mbr_funnel u_funnel (
      .src_byte (src_byte),
      .offset   (offset_ff),
      .remaining(rem_ff),
      .result   (fun)
   );

   assign fifo_full = fill_ff == FILL_W'(FIFO_DEPTH);
   assign fifo_empty = fill_ff == '0;
   // Past the end of data, or inside a started phantom byte, the bits are ones.
   assign use_phantom = phantom_ff || fifo_empty;
   assign src_byte = use_phantom ? PHANTOM_BYTE : head_ff;
   assign fetch_needed = (op_ff != OP_PUSH) && (rem_ff != '0) && !use_phantom &&
                         !head_valid_ff;
   assign step_ok = (op_ff != OP_PUSH) && (rem_ff != '0) && !fetch_needed;

   assign step_bits = (bits_ff << fun.take) | VALUE_W'(fun.chunk);
   assign step_rem = rem_ff - COUNT_W'(fun.take);
   assign group = step_bits[TAKE_W-1:0];
   assign group_more = (op_ff == OP_READ_INT) && !group[GROUP_LAST_BIT];

   assign exec_done = (op_ff == OP_PUSH) || (rem_ff == '0) ||
                      (step_ok && (step_rem == '0) && !group_more);

   assign rp_next = (rp_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   assign wp_next = (wp_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_ff + 1'b1;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept = req_valid && !req_stall;

   always_comb begin
      case (req_item.opcode)
         OP_READ_BITS: init_rem = (req_item.bit_count > MAX_BIT_COUNT) ?
                                  MAX_BIT_COUNT : req_item.bit_count;
         OP_READ_INT:  init_rem = GROUP_BITS;
         OP_ALIGN:     init_rem = (offset_ff == '0) ? '0 :
                                  COUNT_W'(BYTE_W) - {{(COUNT_W-OFFSET_W){1'b0}}, offset_ff};
         default:      init_rem = '0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (fetch_needed) state_in = S_LOAD;
            else if (exec_done) state_in = S_FINISH;
         end
         S_LOAD: begin
            state_in = S_EXEC;
         end
         S_FINISH: begin
            if (accept) state_in = S_EXEC;
            else if (deliver) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Controls per state.
   always_comb begin
      req_stall = 1'b1;
      deliver = 1'b0;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_EXEC: begin
            ram_wr_en = (op_ff == OP_PUSH) && !fifo_full;
            ram_rd_en = fetch_needed;
         end
         S_LOAD: begin
            req_stall = 1'b1;
         end
         S_FINISH: begin
            deliver = out_free;
            req_stall = !out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      case (op_ff)
         OP_READ_BITS: res_value = bits_ff;
         OP_READ_INT:  res_value = int_ff;
         default:      res_value = '0;
      endcase
      if (op_ff == OP_PUSH) res_status = drop_ff ? ST_DROPPED : ST_OK;
      else if (padded_ff) res_status = ST_PADDED;
      else if (ovf_ff) res_status = ST_OVERFLOW;
      else res_status = ST_OK;
   end

   // Datapath next values.
   always_comb begin
      op_in = op_ff;
      byte_in = byte_ff;
      rem_in = rem_ff;
      bits_in = bits_ff;
      int_in = int_ff;
      padded_in = padded_ff;
      ovf_in = ovf_ff;
      drop_in = drop_ff;
      rp_in = rp_ff;
      wp_in = wp_ff;
      fill_in = fill_ff;
      offset_in = offset_ff;
      phantom_in = phantom_ff;
      head_in = head_ff;
      head_valid_in = head_valid_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (accept) begin
         op_in = req_item.opcode;
         byte_in = req_item.byte_value;
         rem_in = init_rem;
         bits_in = '0;
         int_in = '0;
         padded_in = 1'b0;
         ovf_in = 1'b0;
         drop_in = 1'b0;
      end

      if (deliver) begin
         rsp_valid_in = 1'b1;
         rsp_in.field_value = res_value;
         rsp_in.status = res_status;
         rsp_in.at_end = (offset_ff == '0) && fifo_empty && !phantom_ff;
      end

      case (state_ff)
         S_EXEC: begin
            if (op_ff == OP_PUSH) begin
               if (fifo_full) begin
                  drop_in = 1'b1;
               end else begin
                  wp_in = wp_next;
                  fill_in = fill_ff + 1'b1;
               end
            end else if (step_ok) begin
               bits_in = step_bits;
               rem_in = step_rem;
               padded_in = padded_ff || use_phantom;
               offset_in = fun.new_offset;
               if (fun.byte_end) begin
                  // Finish the byte: drop the phantom, or pop the head.
                  phantom_in = 1'b0;
                  if (!use_phantom) begin
                     rp_in = rp_next;
                     fill_in = fill_ff - 1'b1;
                     head_valid_in = 1'b0;
                  end
               end else begin
                  phantom_in = use_phantom;
               end
               if ((op_ff == OP_READ_INT) && (step_rem == '0)) begin
                  ovf_in = ovf_ff || (int_ff[VALUE_W-1:OVERFLOW_LSB] != '0);
                  int_in = {int_ff[VALUE_W-4:0], group[GROUP_LAST_BIT-1:0]};
                  if (!group[GROUP_LAST_BIT]) begin
                     rem_in = GROUP_BITS;
                     bits_in = '0;
                  end
               end
            end
         end
         S_LOAD: begin
            head_in = ram_rd_data;
            head_valid_in = 1'b1;
         end
         default: begin
            head_in = head_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rp_ff <= '0;
         wp_ff <= '0;
         fill_ff <= '0;
         offset_ff <= '0;
         phantom_ff <= 1'b0;
         head_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rp_ff <= rp_in;
         wp_ff <= wp_in;
         fill_ff <= fill_in;
         offset_ff <= offset_in;
         phantom_ff <= phantom_in;
         head_valid_ff <= head_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      byte_ff <= byte_in;
      rem_ff <= rem_in;
      bits_ff <= bits_in;
      int_ff <= int_in;
      padded_ff <= padded_in;
      ovf_ff <= ovf_in;
      drop_ff <= drop_in;
      head_ff <= head_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule
`default_nettype wire

[sv/mbr_ram.sv]
`default_nettype none
module mbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/mbr_funnel.sv]
`default_nettype none
module mbr_funnel (
   input  wire logic [mbr_pkg::BYTE_W-1:0]   src_byte,
   input  wire logic [mbr_pkg::OFFSET_W-1:0] offset,
   input  wire logic [mbr_pkg::COUNT_W-1:0]  remaining,
   output mbr_pkg::funnel_type               result
);
   import mbr_pkg::*;

   logic [TAKE_W-1:0] avail;
   logic [TAKE_W-1:0] take;
   logic [BYTE_W-1:0] shifted;
   logic [TAKE_W-1:0] offset_sum;

   // Take what is left of the byte or what the request still needs, whichever is less.
   assign avail = TAKE_W'(BYTE_W) - {1'b0, offset};
   assign take = (remaining > {{(COUNT_W-TAKE_W){1'b0}}, avail}) ?
                 avail : remaining[TAKE_W-1:0];
   assign shifted = src_byte << offset;
   assign offset_sum = {1'b0, offset} + take;

   always_comb begin
      result.take = take;
      result.chunk = shifted >> (TAKE_W'(BYTE_W) - take);
      result.new_offset = offset_sum[OFFSET_W-1:0];
      result.byte_end = offset_sum[OFFSET_W];
   end

endmodule
`default_nettype wire

[sim/msb_bit_reader_octal_varint_top_tb.sv]
`timescale 1ns / 1ps

module msb_bit_reader_octal_varint_top_tb;
   import mbr_pkg::*;

   localparam int DEPTH = FIFO_DEPTH_DEFAULT;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 200;

   // Tracks the reader state and the fields each accepted item should produce.
   class field_scoreboard;
      logic [BYTE_W-1:0] held_bytes [DEPTH];
      int head;
      int tail;
      int count;
      bit [OFFSET_W-1:0] bit_pos;
      bit in_phantom;
      bit pad_seen;
      rsp_type awaited_fields [$];
      int errors;

      function new();
         head = 0;
         tail = 0;
         count = 0;
         bit_pos = '0;
         in_phantom = 1'b0;
         pad_seen = 1'b0;
         errors = 0;
      endfunction

      task report(input string what);
         errors++;
         $display("ERROR %0t: %s", $time, what);
      endtask

      // Take one bit, most significant first; an empty FIFO yields ones.
      function bit next_bit();
         bit b;
         if (in_phantom || count == 0) begin
            in_phantom = 1'b1;
            pad_seen = 1'b1;
            b = 1'b1;
         end else begin
            b = held_bytes[head][3'd7 - bit_pos];
         end
         if (bit_pos == 3'd7) begin
            if (in_phantom) begin
               in_phantom = 1'b0;
            end else begin
               head = (head + 1) % DEPTH;
               count--;
            end
         end
         bit_pos++;
         return b;
      endfunction

      function logic [VALUE_W-1:0] next_bits(input int n);
         logic [VALUE_W-1:0] v;
         v = '0;
         for (int i = 0; i < n; i++)
            v = {v[VALUE_W-2:0], next_bit()};
         return v;
      endfunction

      function void note_request(input req_type r);
         rsp_type e;
         logic [VALUE_W-1:0] acc;
         logic [VALUE_W-1:0] grp;
         int n;
         bit ovf;
         e = '0;
         e.status = ST_OK;
         pad_seen = 1'b0;
         ovf = 1'b0;
         case (r.opcode)
            OP_PUSH: begin
               if (count >= DEPTH) begin
                  e.status = ST_DROPPED;
               end else begin
                  held_bytes[tail] = r.byte_value;
                  tail = (tail + 1) % DEPTH;
                  count++;
               end
            end
            OP_READ_BITS: begin
               n = (r.bit_count > MAX_BIT_COUNT) ? int'(MAX_BIT_COUNT) : int'(r.bit_count);
               e.field_value = next_bits(n);
            end
            OP_READ_INT: begin
               acc = '0;
               do begin
                  grp = next_bits(int'(GROUP_BITS));
                  if (acc[VALUE_W-1:OVERFLOW_LSB] != 0)
                     ovf = 1'b1;
                  acc = {acc[VALUE_W-4:0], grp[2:0]};
               end while (!grp[GROUP_LAST_BIT]);
               e.field_value = acc;
            end
            OP_ALIGN: begin
               if (bit_pos != 0)
                  void'(next_bits(8 - int'(bit_pos)));
            end
            default: begin
            end
         endcase
         if (r.opcode != OP_PUSH) begin
            if (pad_seen)
               e.status = ST_PADDED;
            else if (ovf)
               e.status = ST_OVERFLOW;
         end
         e.at_end = (bit_pos == 0 && count == 0 && !in_phantom);
         awaited_fields.push_back(e);
      endfunction

      task check_result(input rsp_type got);
         rsp_type e;
         if (awaited_fields.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         e = awaited_fields.pop_front();
         if (got.field_value !== e.field_value)
            report($sformatf("field_value %h, want %h", got.field_value, e.field_value));
         if (got.status !== e.status)
            report($sformatf("status %0d, want %0d", got.status, e.status));
         if (got.at_end !== e.at_end)
            report($sformatf("at_end %b, want %b", got.at_end, e.at_end));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;

   field_scoreboard sb;
   int  src_idle_pct;
   int  sink_idle_pct;
   int  items_sent;
   bit  hold_wanted;
   int  hold_left;

   msb_bit_reader_octal_varint_top #(
      .FIFO_DEPTH(DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one item and hold it until accepted; returns on the next falling edge.
   task automatic issue(input opcode_type op, input logic [BYTE_W-1:0] b,
                        input logic [COUNT_W-1:0] n);
      req_type r;
      r.opcode = op;
      r.byte_value = b;
      r.bit_count = n;
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      items_sent++;
      @(negedge clock);
   endtask

   // Consume whatever is left so the next pushes start on a clean boundary.
   task automatic drain_reader();
      if (sb.bit_pos != 0)
         issue(OP_ALIGN, BYTE_W'($urandom), COUNT_W'($urandom));
      while (sb.count != 0)
         issue(OP_READ_BITS, BYTE_W'($urandom), (sb.count >= 4) ? 6'd32 : 6'(sb.count * 8));
   endtask

   task automatic varint_sequence();
      int groups;
      logic [3:0] hi;
      logic [3:0] lo;
      if ($urandom_range(3) != 0)
         drain_reader();
      groups = ($urandom_range(3) == 0) ? $urandom_range(11, 14) : $urandom_range(1, 10);
      for (int i = 0; i < groups; i += 2) begin
         hi = {1'(i == groups - 1), 3'($urandom_range(7))};
         if (i + 1 < groups)
            lo = {1'(i + 1 == groups - 1), 3'($urandom_range(7))};
         else
            lo = 4'($urandom_range(15));
         issue(OP_PUSH, {hi, lo}, COUNT_W'($urandom));
      end
      issue(OP_READ_INT, BYTE_W'($urandom), COUNT_W'($urandom));
   endtask

   task automatic field_sequence();
      repeat ($urandom_range(1, 4))
         issue(OP_PUSH, BYTE_W'($urandom), COUNT_W'($urandom));
      repeat ($urandom_range(1, 3))
         issue(OP_READ_BITS, BYTE_W'($urandom), COUNT_W'($urandom_range(1, 32)));
      if ($urandom_range(3) == 0)
         issue(OP_ALIGN, BYTE_W'($urandom), COUNT_W'($urandom));
   endtask

   task automatic run_random(input int upto);
      int roll;
      while (items_sent < upto) begin
         roll = $urandom_range(99);
         if (roll < 45) begin
            varint_sequence();
         end else if (roll < 60) begin
            field_sequence();
         end else if (roll < 70) begin
            repeat ($urandom_range(14, 20))
               issue(OP_PUSH, BYTE_W'($urandom), COUNT_W'($urandom));
         end else begin
            issue(opcode_type'($urandom_range(3)), BYTE_W'($urandom), COUNT_W'($urandom));
         end
      end
   endtask

   // Receiver: random stall, or a long hold-off when requested.
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (sink_idle_pct != 0) && ($urandom_range(99) < sink_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_item);
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      src_idle_pct = 17;
      sink_idle_pct = 77;
      items_sent = 0;
      hold_wanted = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero-length read, then reads that run into and through a phantom byte
      issue(OP_READ_BITS, 8'h00, 6'd0);
      issue(OP_READ_BITS, 8'hFF, 6'd5);
      issue(OP_PUSH, 8'h00, 6'd63);
      issue(OP_READ_BITS, 8'h00, 6'd63);
      issue(OP_ALIGN, 8'h00, 6'd0);
      // fill to the brim and drop one; the first integer ends in the seventh byte
      repeat (6) issue(OP_PUSH, 8'h77, 6'd0);
      issue(OP_PUSH, 8'h7F, 6'd0);
      repeat (DEPTH - 7) issue(OP_PUSH, 8'h77, 6'd0);
      issue(OP_PUSH, 8'hFF, 6'd63);
      issue(OP_READ_INT, 8'h00, 6'd0);
      // remaining groups never end: padding and overflow together
      issue(OP_READ_INT, 8'h00, 6'd0);
      issue(OP_ALIGN, 8'h00, 6'd0);
      issue(OP_ALIGN, 8'hFF, 6'd63);

      run_random(items_sent + 580);
      src_idle_pct = 77;
      sink_idle_pct = 17;
      run_random(items_sent + 580);
      src_idle_pct = 0;
      sink_idle_pct = 0;
      hold_wanted = 1'b1;
      run_random(items_sent + 590);
      req_valid <= 1'b0;

      while (sb.awaited_fields.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.awaited_fields.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.awaited_fields.size()));
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
